// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file aclk_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ACLK_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define ACLK_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define ACLK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/aclk_pkg.sv =====
`timescale 1ns / 1ps

package aclk_pkg;

    // Field widths
    localparam int HOURS_W   = 5;
    localparam int MINSEC_W  = 6;
    localparam int TICK_W    = 16;
    localparam int KEY_W     = 4;
    localparam int ENTRY_W   = 7;
    localparam int MODE_W    = 2;
    localparam int FIELD_W   = 2;

    // Limits and reset values
    localparam logic [HOURS_W-1:0]  HOUR_LIMIT   = 5'd23;
    localparam logic [MINSEC_W-1:0] MINSEC_LIMIT = 6'd59;
    localparam logic [TICK_W-1:0]   TPS_RESET    = 16'd600;
    localparam logic [ENTRY_W-1:0]  DECIMAL_BASE = 7'd10;
    localparam logic [KEY_W-1:0]    LAST_DIGIT   = 4'd9;

    // Event kinds
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_KEY  = 1'b1;

    // Key codes
    localparam logic [KEY_W-1:0] KEY_EDIT_TIME  = 4'd10;
    localparam logic [KEY_W-1:0] KEY_SET_ALARM  = 4'd11;
    localparam logic [KEY_W-1:0] KEY_STOP_ALARM = 4'd12;

    // Edit mode codes as seen on the edit_mode output
    localparam logic [MODE_W-1:0] EDIT_IDLE  = 2'd0;
    localparam logic [MODE_W-1:0] EDIT_CLOCK = 2'd1;
    localparam logic [MODE_W-1:0] EDIT_ALARM = 2'd2;

    // Field codes as seen on the edit_field output
    localparam logic [FIELD_W-1:0] FIELD_HOURS   = 2'd0;
    localparam logic [FIELD_W-1:0] FIELD_MINUTES = 2'd1;
    localparam logic [FIELD_W-1:0] FIELD_SECONDS = 2'd2;

    // Digit phase codes
    localparam logic DIGIT_TENS  = 1'b0;
    localparam logic DIGIT_UNITS = 1'b1;

    typedef struct packed {
        logic [HOURS_W-1:0]  hours;
        logic [MINSEC_W-1:0] minutes;
        logic [MINSEC_W-1:0] seconds;
    } time_t;

    // Upper limit of a time field, widened to the entry width
    function automatic logic [ENTRY_W-1:0] field_limit(input logic [FIELD_W-1:0] f);
        field_limit = (f == FIELD_HOURS) ? ENTRY_W'(HOUR_LIMIT) : ENTRY_W'(MINSEC_LIMIT);
    endfunction

endpackage

// ===== hw/rtl/alarm_clock_with_keypad_entry.sv =====
`timescale 1ns / 1ps
// Channel  Handshake                 Payload
// in       in_valid / in_stall       cmd, key_code
// out      out_valid / out_stall     hours, minutes, seconds, alarm_active, speaker,
//                                    edit_mode, edit_field, edit_digit, entry_value
// cfg      cfg_valid / cfg_ready     cfg_data (ticks_per_second)
//
// Each event passes through the input register, then through the clock and entry
// logic into the result register.
// One event is accepted per cycle while in_stall is low; the clock state updates
// as the event leaves the input register, so the next event sees it at once.
// Reset (rst_n low) clears the clock to 00:00:00, sets the alarm to 23:59:59
// and the rate to 600 ticks per second. A stall on out holds the result and
// backs up into in_stall only when the input register is also full.

module alarm_clock_with_keypad_entry (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [aclk_pkg::TICK_W-1:0]           cfg_data,
    // event input
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  cmd,
    input  logic [aclk_pkg::KEY_W-1:0]            key_code,
    // result output
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [aclk_pkg::HOURS_W-1:0]          hours,
    output logic [aclk_pkg::MINSEC_W-1:0]         minutes,
    output logic [aclk_pkg::MINSEC_W-1:0]         seconds,
    output logic                                  alarm_active,
    output logic                                  speaker,
    output logic [aclk_pkg::MODE_W-1:0]           edit_mode,
    output logic [aclk_pkg::FIELD_W-1:0]          edit_field,
    output logic                                  edit_digit,
    output logic [aclk_pkg::ENTRY_W-1:0]          entry_value
);

    typedef enum logic [aclk_pkg::MODE_W-1:0] {
        MODE_IDLE  = aclk_pkg::EDIT_IDLE,
        MODE_CLOCK = aclk_pkg::EDIT_CLOCK,
        MODE_ALARM = aclk_pkg::EDIT_ALARM
    } mode_t;

    // Configuration
    logic [aclk_pkg::TICK_W-1:0]  tps_reg;

    // Input register
    logic                         s1_valid_reg;
    logic                         s1_cmd_reg;
    logic [aclk_pkg::KEY_W-1:0]   s1_key_reg;

    // Clock state
    aclk_pkg::time_t              clock_reg, clock_next;
    aclk_pkg::time_t              alarm_reg, alarm_next;
    logic [aclk_pkg::TICK_W-1:0]  tick_reg, tick_next;
    logic                         latch_reg, latch_next;
    logic                         spk_reg, spk_next;
    mode_t                        mode_reg, mode_next;
    logic [aclk_pkg::FIELD_W-1:0] field_reg, field_next;
    logic                         digit_reg, digit_next;
    logic [aclk_pkg::KEY_W-1:0]   partial_reg, partial_next;

    // Result register
    logic                         out_valid_reg;
    aclk_pkg::time_t              res_time_reg;
    logic                         res_latch_reg;
    logic                         res_spk_reg;
    logic [aclk_pkg::MODE_W-1:0]  res_mode_reg;
    logic [aclk_pkg::FIELD_W-1:0] res_field_reg;
    logic                         res_digit_reg;
    logic [aclk_pkg::ENTRY_W-1:0] res_value_reg;

    logic                         advance;
    logic                         in_accept;
    logic                         do_step;

    // Handshake
    assign advance   = !out_valid_reg || !out_stall;
    assign in_stall  = s1_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;
    assign do_step   = s1_valid_reg && advance;
    assign cfg_ready = 1'b1;

    // Capture configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tps_reg <= aclk_pkg::TPS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            tps_reg <= cfg_data;
        end
    end

    // Hold the accepted event in the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_cmd_reg <= cmd;
            s1_key_reg <= key_code;
        end
    end

    // Next clock state for the event in the input register
    always_comb
    begin
        aclk_pkg::time_t              tgt;
        logic [aclk_pkg::TICK_W-1:0]  tick_inc;
        logic [aclk_pkg::ENTRY_W-1:0] sum;
        logic [aclk_pkg::FIELD_W-1:0] f;

        clock_next   = clock_reg;
        alarm_next   = alarm_reg;
        tick_next    = tick_reg;
        latch_next   = latch_reg;
        spk_next     = spk_reg;
        mode_next    = mode_reg;
        field_next   = field_reg;
        digit_next   = digit_reg;
        partial_next = partial_reg;
        tgt          = (mode_reg == MODE_CLOCK) ? clock_reg : alarm_reg;
        tick_inc     = tick_reg + 1'b1;
        sum          = aclk_pkg::ENTRY_W'(partial_reg) * aclk_pkg::DECIMAL_BASE
                       + aclk_pkg::ENTRY_W'(s1_key_reg);
        f            = (field_reg > aclk_pkg::FIELD_SECONDS) ? aclk_pkg::FIELD_SECONDS
                                                             : field_reg;

        if (s1_cmd_reg == aclk_pkg::CMD_TICK)
        begin
            // Count ticks and advance one second; clock entry holds the clock; a latched alarm toggles the speaker
            if (mode_reg != MODE_CLOCK)
            begin
                if (tick_inc >= tps_reg)
                begin
                    tick_next = '0;
                    if (clock_reg.seconds != aclk_pkg::MINSEC_LIMIT)
                    begin
                        clock_next.seconds = clock_reg.seconds + 1'b1;
                    end
                    else
                    begin
                        clock_next.seconds = '0;
                        if (clock_reg.minutes != aclk_pkg::MINSEC_LIMIT)
                        begin
                            clock_next.minutes = clock_reg.minutes + 1'b1;
                        end
                        else
                        begin
                            clock_next.minutes = '0;
                            if (clock_reg.hours != aclk_pkg::HOUR_LIMIT)
                            begin
                                clock_next.hours = clock_reg.hours + 1'b1;
                            end
                            else
                            begin
                                clock_next.hours = '0;
                            end
                        end
                    end
                end
                else
                begin
                    tick_next = tick_inc;
                end
            end
            if (latch_reg)
            begin
                spk_next = !spk_reg;
            end
        end
        else if (mode_reg != MODE_IDLE)
        begin
            // Digit entry; other keys are dropped while editing
            if (s1_key_reg <= aclk_pkg::LAST_DIGIT)
            begin
                if (digit_reg == aclk_pkg::DIGIT_TENS)
                begin
                    partial_next = s1_key_reg;
                    digit_next   = aclk_pkg::DIGIT_UNITS;
                    case (f)
                        aclk_pkg::FIELD_HOURS:   tgt.hours   = aclk_pkg::HOURS_W'(s1_key_reg);
                        aclk_pkg::FIELD_MINUTES: tgt.minutes = aclk_pkg::MINSEC_W'(s1_key_reg);
                        default:                 tgt.seconds = aclk_pkg::MINSEC_W'(s1_key_reg);
                    endcase
                end
                else
                begin
                    digit_next   = aclk_pkg::DIGIT_TENS;
                    partial_next = '0;
                    if (sum > aclk_pkg::field_limit(f))
                    begin
                        // Out of range: clear the field and enter it again
                        case (f)
                            aclk_pkg::FIELD_HOURS:   tgt.hours   = '0;
                            aclk_pkg::FIELD_MINUTES: tgt.minutes = '0;
                            default:                 tgt.seconds = '0;
                        endcase
                    end
                    else
                    begin
                        case (f)
                            aclk_pkg::FIELD_HOURS:   tgt.hours   = aclk_pkg::HOURS_W'(sum);
                            aclk_pkg::FIELD_MINUTES: tgt.minutes = aclk_pkg::MINSEC_W'(sum);
                            default:                 tgt.seconds = aclk_pkg::MINSEC_W'(sum);
                        endcase
                        if (f == aclk_pkg::FIELD_SECONDS)
                        begin
                            if (mode_reg == MODE_CLOCK)
                            begin
                                tick_next = '0;
                            end
                            mode_next  = MODE_IDLE;
                            field_next = aclk_pkg::FIELD_HOURS;
                        end
                        else
                        begin
                            field_next = f + 1'b1;
                        end
                    end
                end
                if (mode_reg == MODE_CLOCK)
                begin
                    clock_next = tgt;
                end
                else
                begin
                    alarm_next = tgt;
                end
            end
        end
        else
        begin
            // Idle keys: start entry or stop the alarm
            case (s1_key_reg)
                aclk_pkg::KEY_EDIT_TIME,
                aclk_pkg::KEY_SET_ALARM:
                begin
                    mode_next    = (s1_key_reg == aclk_pkg::KEY_EDIT_TIME) ? MODE_CLOCK
                                                                           : MODE_ALARM;
                    field_next   = aclk_pkg::FIELD_HOURS;
                    digit_next   = aclk_pkg::DIGIT_TENS;
                    partial_next = '0;
                end
                aclk_pkg::KEY_STOP_ALARM:
                begin
                    latch_next = 1'b0;
                    spk_next   = 1'b0;
                end
                default:
                begin
                end
            endcase
        end

        // Latch the alarm on a time match while not editing
        if (mode_next == MODE_IDLE && clock_next == alarm_next)
        begin
            latch_next = 1'b1;
        end
    end

    // Update the clock state as the event moves to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_reg   <= '0;
            alarm_reg   <= '{hours:   aclk_pkg::HOUR_LIMIT,
                             minutes: aclk_pkg::MINSEC_LIMIT,
                             seconds: aclk_pkg::MINSEC_LIMIT};
            tick_reg    <= '0;
            latch_reg   <= 1'b0;
            spk_reg     <= 1'b0;
            mode_reg    <= MODE_IDLE;
            field_reg   <= aclk_pkg::FIELD_HOURS;
            digit_reg   <= aclk_pkg::DIGIT_TENS;
            partial_reg <= '0;
        end
        else if (do_step)
        begin
            clock_reg   <= clock_next;
            alarm_reg   <= alarm_next;
            tick_reg    <= tick_next;
            latch_reg   <= latch_next;
            spk_reg     <= spk_next;
            mode_reg    <= mode_next;
            field_reg   <= field_next;
            digit_reg   <= digit_next;
            partial_reg <= partial_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_step)
        begin
            res_time_reg  <= clock_next;
            res_latch_reg <= latch_next;
            res_spk_reg   <= spk_next;
            res_mode_reg  <= mode_next;
            if (mode_next != MODE_IDLE)
            begin
                res_field_reg <= field_next;
                res_digit_reg <= digit_next;
                res_value_reg <= aclk_pkg::ENTRY_W'(partial_next);
            end
            else
            begin
                res_field_reg <= aclk_pkg::FIELD_HOURS;
                res_digit_reg <= aclk_pkg::DIGIT_TENS;
                res_value_reg <= '0;
            end
        end
    end

    // Drive the result ports
    assign out_valid    = out_valid_reg;
    assign hours        = res_time_reg.hours;
    assign minutes      = res_time_reg.minutes;
    assign seconds      = res_time_reg.seconds;
    assign alarm_active = res_latch_reg;
    assign speaker      = res_spk_reg;
    assign edit_mode    = res_mode_reg;
    assign edit_field   = res_field_reg;
    assign edit_digit   = res_digit_reg;
    assign entry_value  = res_value_reg;

endmodule

// ===== hw/rtl/aclk_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module aclk_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [aclk_pkg::HOURS_W-1:0]  hours,
    input  logic [aclk_pkg::MINSEC_W-1:0] minutes,
    input  logic [aclk_pkg::MINSEC_W-1:0] seconds,
    input  logic [aclk_pkg::MODE_W-1:0]   edit_mode,
    input  logic [aclk_pkg::FIELD_W-1:0]  edit_field,
    input  logic                          edit_digit,
    input  logic [aclk_pkg::ENTRY_W-1:0]  entry_value
);

    // A stalled transaction keeps its time fields
    `ACLK_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(hours) && $stable(minutes) && $stable(seconds), "stalled result changed")

    // Time fields stay within their roll-over limits
    `ACLK_ASSERT_IMPL(a_time_range, clk, rst_n, out_valid, hours <= aclk_pkg::HOUR_LIMIT && minutes <= aclk_pkg::MINSEC_LIMIT && seconds <= aclk_pkg::MINSEC_LIMIT, "time field out of range")

    // Entry status reads zero while not editing
    `ACLK_ASSERT_IMPL(a_idle_entry, clk, rst_n, out_valid && edit_mode == aclk_pkg::EDIT_IDLE, edit_field == aclk_pkg::FIELD_HOURS && edit_digit == aclk_pkg::DIGIT_TENS && entry_value == '0, "entry status set while idle")

    // Between digits the partial value is a single decimal digit
    `ACLK_ASSERT_IMPL(a_partial_digit, clk, rst_n, out_valid && edit_digit == aclk_pkg::DIGIT_UNITS, entry_value <= aclk_pkg::ENTRY_W'(aclk_pkg::LAST_DIGIT) && edit_mode != aclk_pkg::EDIT_IDLE, "bad partial entry value")

endmodule

bind alarm_clock_with_keypad_entry aclk_checker u_aclk_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .hours       (hours),
    .minutes     (minutes),
    .seconds     (seconds),
    .edit_mode   (edit_mode),
    .edit_field  (edit_field),
    .edit_digit  (edit_digit),
    .entry_value (entry_value)
);

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam logic [aclk_pkg::KEY_W-1:0] KEY_TOP = 4'd15;
    localparam int HOLD_CYCLES  = 150;
    localparam int DRAIN_CYCLES = 10;
    localparam int DRAIN_LIMIT  = 20000;

    typedef struct packed {
        logic [aclk_pkg::HOURS_W-1:0]  hours;
        logic [aclk_pkg::MINSEC_W-1:0] minutes;
        logic [aclk_pkg::MINSEC_W-1:0] seconds;
        logic                          alarm_active;
        logic                          speaker;
        logic [aclk_pkg::MODE_W-1:0]   edit_mode;
        logic [aclk_pkg::FIELD_W-1:0]  edit_field;
        logic                          edit_digit;
        logic [aclk_pkg::ENTRY_W-1:0]  entry_value;
    } readout_t;

    // Tracks the clock and keypad state and holds the readouts still owed by the block
    class clock_tracker;
        logic [aclk_pkg::TICK_W-1:0]   rate;
        logic [aclk_pkg::MINSEC_W-1:0] clock_f[3];
        logic [aclk_pkg::MINSEC_W-1:0] alarm_f[3];
        logic [aclk_pkg::TICK_W-1:0]   tick_cnt;
        logic                          latch;
        logic                          spk;
        logic [aclk_pkg::MODE_W-1:0]   mode;
        logic [aclk_pkg::FIELD_W-1:0]  fld;
        logic                          dig;
        logic [aclk_pkg::ENTRY_W-1:0]  part;
        readout_t                      due[$];
        int                            errors;
        int                            checked;
        int                            latches;
        int                            entries_done;

        function new();
            rate = aclk_pkg::TPS_RESET;
            clock_f = '{6'd0, 6'd0, 6'd0};
            alarm_f = '{6'(aclk_pkg::HOUR_LIMIT), aclk_pkg::MINSEC_LIMIT,
                        aclk_pkg::MINSEC_LIMIT};
            tick_cnt = '0;
            latch = 1'b0;
            spk = 1'b0;
            mode = aclk_pkg::EDIT_IDLE;
            fld = aclk_pkg::FIELD_HOURS;
            dig = aclk_pkg::DIGIT_TENS;
            part = '0;
            errors = 0;
            checked = 0;
            latches = 0;
            entries_done = 0;
        endfunction

        function void set_rate(logic [aclk_pkg::TICK_W-1:0] r);
            rate = r;
        endfunction

        function logic [aclk_pkg::MINSEC_W-1:0] limit_of(int f);
            return (f == aclk_pkg::FIELD_HOURS) ? 6'(aclk_pkg::HOUR_LIMIT)
                                                : aclk_pkg::MINSEC_LIMIT;
        endfunction

        // Ripple one second through seconds, minutes and hours
        function void advance_second();
            logic [aclk_pkg::MINSEC_W:0] v;
            bit carry;
            carry = 1'b1;
            for (int f = int'(aclk_pkg::FIELD_SECONDS); f >= int'(aclk_pkg::FIELD_HOURS); f--)
            begin
                if (carry)
                begin
                    v = clock_f[f] + 7'd1;
                    if (v > limit_of(f))
                    begin
                        clock_f[f] = '0;
                    end
                    else
                    begin
                        clock_f[f] = v[aclk_pkg::MINSEC_W-1:0];
                        carry = 1'b0;
                    end
                end
            end
        endfunction

        function void put_field(logic [aclk_pkg::FIELD_W-1:0] f,
                                logic [aclk_pkg::MINSEC_W-1:0] v);
            if (mode == aclk_pkg::EDIT_CLOCK)
                clock_f[f] = v;
            else
                alarm_f[f] = v;
        endfunction

        // Apply one keypad digit while entering a time
        function void take_digit(logic [aclk_pkg::KEY_W-1:0] k);
            logic [aclk_pkg::FIELD_W-1:0] f;
            f = fld;
            if (k > aclk_pkg::LAST_DIGIT)
                return;
            if (dig == aclk_pkg::DIGIT_TENS)
            begin
                part = aclk_pkg::ENTRY_W'(k);
                put_field(f, aclk_pkg::MINSEC_W'(k));
                dig = aclk_pkg::DIGIT_UNITS;
                return;
            end
            part = part * 7'd10 + aclk_pkg::ENTRY_W'(k);
            dig = aclk_pkg::DIGIT_TENS;
            // out of range: clear the field and take it again
            if (part > aclk_pkg::ENTRY_W'(limit_of(f)))
            begin
                put_field(f, '0);
                part = '0;
                return;
            end
            put_field(f, part[aclk_pkg::MINSEC_W-1:0]);
            part = '0;
            if (f == aclk_pkg::FIELD_SECONDS)
            begin
                if (mode == aclk_pkg::EDIT_CLOCK)
                    tick_cnt = '0;
                mode = aclk_pkg::EDIT_IDLE;
                fld = aclk_pkg::FIELD_HOURS;
                entries_done++;
            end
            else
            begin
                fld = f + 2'd1;
            end
        endfunction

        // Advance the state by one accepted event and queue the readout it owes
        function void note_event(logic c, logic [aclk_pkg::KEY_W-1:0] k);
            readout_t r;
            logic was;
            was = latch;
            if (c == aclk_pkg::CMD_TICK)
            begin
                if (mode != aclk_pkg::EDIT_CLOCK)
                begin
                    tick_cnt = tick_cnt + 16'd1;
                    if (tick_cnt >= rate)
                    begin
                        tick_cnt = '0;
                        advance_second();
                    end
                end
                if (latch)
                    spk = ~spk;
            end
            else if (mode != aclk_pkg::EDIT_IDLE)
            begin
                take_digit(k);
            end
            else if (k == aclk_pkg::KEY_EDIT_TIME || k == aclk_pkg::KEY_SET_ALARM)
            begin
                mode = (k == aclk_pkg::KEY_EDIT_TIME) ? aclk_pkg::EDIT_CLOCK
                                                      : aclk_pkg::EDIT_ALARM;
                fld = aclk_pkg::FIELD_HOURS;
                dig = aclk_pkg::DIGIT_TENS;
                part = '0;
            end
            else if (k == aclk_pkg::KEY_STOP_ALARM)
            begin
                latch = 1'b0;
                spk = 1'b0;
            end
            // compare against the alarm only outside entry
            if (mode == aclk_pkg::EDIT_IDLE
                && clock_f[aclk_pkg::FIELD_HOURS] == alarm_f[aclk_pkg::FIELD_HOURS]
                && clock_f[aclk_pkg::FIELD_MINUTES] == alarm_f[aclk_pkg::FIELD_MINUTES]
                && clock_f[aclk_pkg::FIELD_SECONDS] == alarm_f[aclk_pkg::FIELD_SECONDS])
                latch = 1'b1;
            if (latch && !was)
                latches++;
            r.hours        = clock_f[aclk_pkg::FIELD_HOURS][aclk_pkg::HOURS_W-1:0];
            r.minutes      = clock_f[aclk_pkg::FIELD_MINUTES];
            r.seconds      = clock_f[aclk_pkg::FIELD_SECONDS];
            r.alarm_active = latch;
            r.speaker      = spk;
            r.edit_mode    = mode;
            r.edit_field   = (mode != aclk_pkg::EDIT_IDLE) ? fld : aclk_pkg::FIELD_HOURS;
            r.edit_digit   = (mode != aclk_pkg::EDIT_IDLE) ? dig : aclk_pkg::DIGIT_TENS;
            r.entry_value  = (mode != aclk_pkg::EDIT_IDLE) ? part : '0;
            due.push_back(r);
        endfunction

        task report_mismatch(input string msg);
            errors++;
            if (errors <= 40)
                $display("mismatch: %s", msg);
        endtask

        task cmp(input string name, input logic [7:0] got, input logic [7:0] want);
            if (got !== want)
                report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                    checked, name, got, want));
        endtask

        // Match one transaction from the result port against the oldest readout owed
        task check_readout(input readout_t got);
            readout_t want;
            if (due.size() == 0)
            begin
                report_mismatch("result with no event outstanding");
                return;
            end
            want = due.pop_front();
            checked++;
            cmp("hours", 8'(got.hours), 8'(want.hours));
            cmp("minutes", 8'(got.minutes), 8'(want.minutes));
            cmp("seconds", 8'(got.seconds), 8'(want.seconds));
            cmp("alarm_active", 8'(got.alarm_active), 8'(want.alarm_active));
            cmp("speaker", 8'(got.speaker), 8'(want.speaker));
            cmp("edit_mode", 8'(got.edit_mode), 8'(want.edit_mode));
            cmp("edit_field", 8'(got.edit_field), 8'(want.edit_field));
            cmp("edit_digit", 8'(got.edit_digit), 8'(want.edit_digit));
            cmp("entry_value", 8'(got.entry_value), 8'(want.entry_value));
        endtask
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [aclk_pkg::TICK_W-1:0]   cfg_data;
    logic                          in_valid;
    logic                          in_stall;
    logic                          cmd;
    logic [aclk_pkg::KEY_W-1:0]    key_code;
    logic                          out_valid;
    logic                          out_stall;
    logic [aclk_pkg::HOURS_W-1:0]  hours;
    logic [aclk_pkg::MINSEC_W-1:0] minutes;
    logic [aclk_pkg::MINSEC_W-1:0] seconds;
    logic                          alarm_active;
    logic                          speaker;
    logic [aclk_pkg::MODE_W-1:0]   edit_mode;
    logic [aclk_pkg::FIELD_W-1:0]  edit_field;
    logic                          edit_digit;
    logic [aclk_pkg::ENTRY_W-1:0]  entry_value;

    clock_tracker book = new();
    int sent;
    bit quiet;
    bit hold_req;

    alarm_clock_with_keypad_entry dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .key_code     (key_code),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .hours        (hours),
        .minutes      (minutes),
        .seconds      (seconds),
        .alarm_active (alarm_active),
        .speaker      (speaker),
        .edit_mode    (edit_mode),
        .edit_field   (edit_field),
        .edit_digit   (edit_digit),
        .entry_value  (entry_value)
    );

    // 50 MHz clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Bound the run
    initial
    begin
        #20_000_000;
        $display("tb_top: errors");
        $finish;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet)
            return 0;
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Drive one event transaction and hold it until accepted
    task automatic send_event(input logic c, input logic [aclk_pkg::KEY_W-1:0] k);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        cmd = c;
        key_code = k;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        book.note_event(c, k);
        sent++;
    endtask

    task automatic press(input int k);
        send_event(aclk_pkg::CMD_KEY, aclk_pkg::KEY_W'(k));
    endtask

    task automatic tick(input int k);
        send_event(aclk_pkg::CMD_TICK, aclk_pkg::KEY_W'(k));
    endtask

    // Drop valid and wait until every owed readout has come back
    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (book.due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_rate(input logic [aclk_pkg::TICK_W-1:0] r);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data = r;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        book.set_rate(r);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Close any open entry with zero digits
    task automatic finish_entry();
        while (book.mode != aclk_pkg::EDIT_IDLE)
            press(0);
    endtask

    // Key in a full time, optionally with rejected values, ignored keys and ticks mixed in
    task automatic enter_fields(input logic [aclk_pkg::KEY_W-1:0] start_key, input int h,
                                input int m, input int s, input bit rough);
        int vals[3];
        int bad;
        vals = '{h, m, s};
        finish_entry();
        press(start_key);
        for (int f = int'(aclk_pkg::FIELD_HOURS); f <= int'(aclk_pkg::FIELD_SECONDS); f++)
        begin
            if (rough && $urandom_range(0, 3) == 0)
            begin
                bad = (f == aclk_pkg::FIELD_HOURS) ? $urandom_range(24, 99)
                                                   : $urandom_range(60, 99);
                press(bad / 10);
                press(bad % 10);
            end
            if (rough && $urandom_range(0, 5) == 0)
                tick($urandom_range(0, KEY_TOP));
            if (rough && $urandom_range(0, 5) == 0)
                press($urandom_range(aclk_pkg::KEY_EDIT_TIME, KEY_TOP));
            press(vals[f] / 10);
            if (rough && $urandom_range(0, 7) == 0)
                tick($urandom_range(0, KEY_TOP));
            press(vals[f] % 10);
        end
    endtask

    // Set the alarm a few seconds ahead of the clock, or anywhere
    task automatic set_alarm();
        int t;
        finish_entry();
        if ($urandom_range(0, 9) < 7)
        begin
            t = book.clock_f[aclk_pkg::FIELD_HOURS] * 3600
                + book.clock_f[aclk_pkg::FIELD_MINUTES] * 60
                + book.clock_f[aclk_pkg::FIELD_SECONDS] + $urandom_range(0, 8);
            t = t % 86400;
            enter_fields(aclk_pkg::KEY_SET_ALARM, t / 3600, (t / 60) % 60, t % 60,
                         $urandom_range(0, 2) == 0);
        end
        else
        begin
            enter_fields(aclk_pkg::KEY_SET_ALARM, $urandom_range(0, 23),
                         $urandom_range(0, 59), $urandom_range(0, 59),
                         $urandom_range(0, 2) == 0);
        end
    endtask

    // Set the clock, often just short of a rollover
    task automatic set_clock();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3)
            enter_fields(aclk_pkg::KEY_EDIT_TIME, 23, 59, $urandom_range(50, 59),
                         $urandom_range(0, 2) == 0);
        else if (r < 5)
            enter_fields(aclk_pkg::KEY_EDIT_TIME, $urandom_range(0, 23),
                         $urandom_range(0, 59), $urandom_range(55, 59),
                         $urandom_range(0, 2) == 0);
        else
            enter_fields(aclk_pkg::KEY_EDIT_TIME, $urandom_range(0, 23),
                         $urandom_range(0, 59), $urandom_range(0, 59),
                         $urandom_range(0, 2) == 0);
    endtask

    // Mix of full entries, tick runs, stops, noise and abandoned entries
    task automatic random_burst(input int n);
        int stop_at;
        int r;
        stop_at = sent + n;
        while (sent < stop_at)
        begin
            r = $urandom_range(0, 99);
            if (r < 22)
            begin
                set_alarm();
            end
            else if (r < 40)
            begin
                set_clock();
            end
            else if (r < 75)
            begin
                repeat ($urandom_range(1, 30))
                    tick($urandom_range(0, KEY_TOP));
            end
            else if (r < 82)
            begin
                press(aclk_pkg::KEY_STOP_ALARM);
            end
            else if (r < 92)
            begin
                repeat ($urandom_range(1, 6))
                    send_event(1'($urandom), aclk_pkg::KEY_W'($urandom));
            end
            else
            begin
                press($urandom_range(0, 1) ? aclk_pkg::KEY_EDIT_TIME
                                           : aclk_pkg::KEY_SET_ALARM);
                repeat ($urandom_range(1, 5))
                    press($urandom_range(0, KEY_TOP));
            end
        end
    endtask

    // Result side: sample at the rising edge, set the stall at the falling edge
    initial
    begin
        int stall_left;
        int hold_left;
        readout_t got;
        stall_left = 0;
        hold_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                got = {hours, minutes, seconds, alarm_active, speaker,
                       edit_mode, edit_field, edit_digit, entry_value};
                book.check_readout(got);
            end
            @(negedge clk);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall = 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall = 1'b1;
            end
            else
            begin
                stall_left = pick_gap();
                out_stall = (stall_left > 0);
                if (stall_left > 0)
                    stall_left--;
            end
        end
    end

    // Stimulus and end of run
    initial
    begin
        logic [aclk_pkg::TICK_W-1:0] rates[6];
        int guard;
        rst_n = 1'b0;
        in_valid = 1'b0;
        cmd = aclk_pkg::CMD_TICK;
        key_code = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        quiet = 1'b0;
        hold_req = 1'b0;
        sent = 0;
        rates = '{16'd1, 16'd0, 16'd3, 16'd65535, aclk_pkg::TPS_RESET, 16'd0};
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // Directed: ignored keys, clock entry held against ticks, alarm match and stop
        write_rate(16'd2);
        tick(KEY_TOP);
        press(aclk_pkg::KEY_EDIT_TIME);
        tick(0);
        press(2);
        press(aclk_pkg::KEY_SET_ALARM);
        press(3);
        press(5);
        press(9);
        press(5);
        press(9);
        tick(0);
        tick(9);
        press(aclk_pkg::KEY_STOP_ALARM);
        press(aclk_pkg::KEY_SET_ALARM);
        press(9);
        press(9);
        press(0);
        press(0);
        press(6);
        press(0);
        press(0);
        press(0);
        press(0);
        press(1);
        tick(0);
        tick(0);
        press(aclk_pkg::KEY_STOP_ALARM);
        press(14);

        // Random phases, one per tick rate
        foreach (rates[i])
        begin
            settle();
            write_rate((i == 5) ? 16'($urandom_range(4, 40)) : rates[i]);
            if (i == 0)
                hold_req = 1'b1;
            quiet = 1'b1;
            random_burst(40);
            quiet = 1'b0;
            random_burst(175);
        end

        // Drain
        @(negedge clk);
        in_valid = 1'b0;
        guard = 0;
        while (book.due.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (book.due.size() != 0)
            book.report_mismatch($sformatf("%0d results never arrived", book.due.size()));

        $display("summary: %0d events, %0d results checked, tick rates 0, 1, 2, 3, 600, 65535 %s",
                 sent, book.checked, "and one random rate");
        $display("summary: %0d completed time entries, alarm latched %0d times",
                 book.entries_done, book.latches);
        if (book.errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/aclk_pkg.sv
hw/rtl/alarm_clock_with_keypad_entry.sv
hw/rtl/aclk_checker.sv
bench/tb_top.sv
